// ===== rtl/wwcm_pkg.sv =====
// ---------------------------------------------------------------------------
// Wrapped wire channel map package
// Shared widths, codes, payload structs and the sequencer state type for the
// channel/wire map of identical wire-chamber modules.
// ---------------------------------------------------------------------------
package wwcm_pkg;

   // Payload field widths.
   localparam int CH_W    = 22;
   localparam int CRY_W   = 2;
   localparam int VOL_W   = 7;
   localparam int PLANE_W = 2;
   localparam int WIRE_W  = 11;

   // Configuration register widths.
   localparam int CC_W       = 3;
   localparam int MPC_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Internal widths: channels per module, module count product, module index.
   localparam int PER_W    = 14;
   localparam int MODCAP_W = 9;
   localparam int MOD_W    = 8;
   localparam int WNUM_W   = WIRE_W + 1;
   localparam int AU2_W    = WIRE_W + 1;
   localparam int UV2_W    = WIRE_W + 2;

   // Limits on the effective counts.
   localparam int MAX_CRYOSTATS = 4;
   localparam int MAX_MODULES   = 64;

   // Maximum number of wires reported for one channel.
   localparam int MAX_WIRES = 16;
   localparam int WCNT_W    = $clog2(MAX_WIRES);

   // Shared divider: one quotient bit per cycle over the channel width.
   localparam int DIV_STEPS  = CH_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Action codes.
   localparam logic ACTION_C2W = 1'b0;
   localparam logic ACTION_W2C = 1'b1;

   // Plane codes.
   localparam logic [PLANE_W-1:0] PLANE_U    = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_V    = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_Z    = 2'd2;
   localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CRYOSTAT_COUNT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODULES_PER_CRYOSTAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIRES_U              = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIRES_V              = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIRES_Z              = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANCHORED_U           = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ANCHORED_V           = 3'd6;

   // Request payload.
   typedef struct packed {
      logic               action;
      logic [CH_W-1:0]    channel_in;
      logic [CRY_W-1:0]   cryostat_in;
      logic [VOL_W-1:0]   volume_in;
      logic [PLANE_W-1:0] plane_in;
      logic [WIRE_W-1:0]  wire_in;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic               valid_res;
      logic               last;
      logic [CRY_W-1:0]   cryostat_out;
      logic [VOL_W-1:0]   volume_out;
      logic [PLANE_W-1:0] plane_out;
      logic [WIRE_W-1:0]  wire_out;
      logic [CH_W-1:0]    channel_out;
   } rsp_type;

   // Divider command and status.
   typedef struct packed {
      logic             start;
      logic [CH_W-1:0]  dividend;
      logic [PER_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CH_W-1:0]  quot;
      logic [PER_W-1:0] rem;
   } div_rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_CH,
      S_RANGE,
      S_DIV_MOD,
      S_CLASSIFY,
      S_SETUP,
      S_EMIT,
      S_INVALID,
      S_W2C_CHECK,
      S_W2C_DIV,
      S_W2C_OUT
   } state_type;

endpackage

// ===== rtl/wwcm_div.sv =====
// ---------------------------------------------------------------------------
// Wrapped wire channel map divider
// Restoring unsigned divider shared by every division of the block. It
// produces one quotient bit per cycle and holds its result until restarted.
// ---------------------------------------------------------------------------
module wwcm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wwcm_pkg::div_req_type div_req,
   output wwcm_pkg::div_rsp_type div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [wwcm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [wwcm_pkg::PER_W-1:0]     rem_ff, rem_in;
   logic [wwcm_pkg::CH_W-1:0]      quot_ff, quot_in;
   logic [wwcm_pkg::PER_W-1:0]     dvs_ff, dvs_in;

   logic [wwcm_pkg::PER_W:0]       shifted;
   logic [wwcm_pkg::PER_W:0]       diff;
   logic                           fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, quot_ff[wwcm_pkg::CH_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   // Next values of the iteration registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[wwcm_pkg::PER_W-1:0] : shifted[wwcm_pkg::PER_W-1:0];
         quot_in = {quot_ff[wwcm_pkg::CH_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == wwcm_pkg::DIV_CNT_W'(wwcm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

   // A new division is only started once the previous one has finished.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");

   // A finished division leaves a remainder below the divisor.
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== rtl/wwcm_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// Wrapped wire channel map response register
// Output register that holds one response transaction until the receiver
// takes it, so the sequencer can move on while a result waits.
// ---------------------------------------------------------------------------
module wwcm_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wwcm_pkg::rsp_type push_data,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wwcm_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   wwcm_pkg::rsp_type data_ff, data_in;

   // The slot can take a new result when empty or when its content leaves now.
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = push || (valid_ff && rsp_stall);
      data_in  = push ? push_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/wrapped_wire_channel_map_core.sv =====
// ---------------------------------------------------------------------------
// Wrapped wire channel map core
// Maps a readout channel to every wire on it, or a wire to its channel, for
// identical two-volume wire-chamber modules with wrapped induction planes.
// ---------------------------------------------------------------------------
//
//   Port group  Direction  Handshake          Content
//   req_*       in         req_valid/stall    one request transaction
//   rsp_*       out        rsp_valid/stall    one wire or channel per transaction
//   csr_*       in         csr_we             configuration register write
//
// The shared restoring divider yields one quotient bit per cycle over 22 bits
// and is used up to twice per channel lookup and once per wire lookup.
// Reset sets every configuration register to 1 and returns the sequencer to idle.
// Results go through an output register; a new request is taken once the
// final result of the previous one has entered that register.
// ---------------------------------------------------------------------------
module wrapped_wire_channel_map_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wwcm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wwcm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [wwcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wwcm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [wwcm_pkg::CC_W-1:0]   cc_ff, cc_in;
   logic [wwcm_pkg::MPC_W-1:0]  mpc_ff, mpc_in;
   logic [wwcm_pkg::WIRE_W-1:0] wu_ff, wu_in;
   logic [wwcm_pkg::WIRE_W-1:0] wv_ff, wv_in;
   logic [wwcm_pkg::WIRE_W-1:0] wz_ff, wz_in;
   logic [wwcm_pkg::WIRE_W-1:0] au_ff, au_in;
   logic [wwcm_pkg::WIRE_W-1:0] av_ff, av_in;

   // Sequencer and per-transaction registers.
   wwcm_pkg::state_type           state_ff, state_in;
   logic [wwcm_pkg::CH_W-1:0]     ch_ff, ch_in;
   logic [wwcm_pkg::CRY_W-1:0]    cry_ff, cry_in;
   logic [wwcm_pkg::VOL_W-1:0]    vol_ff, vol_in;
   logic [wwcm_pkg::PLANE_W-1:0]  pla_ff, pla_in;
   logic [wwcm_pkg::WNUM_W-1:0]   wnum_ff, wnum_in;
   logic                          odd_ff, odd_in;
   logic [wwcm_pkg::PER_W-1:0]    rr_ff, rr_in;
   logic [wwcm_pkg::WIRE_W-1:0]   a_ff, a_in;
   logic [wwcm_pkg::WIRE_W-1:0]   nw_ff, nw_in;
   logic [wwcm_pkg::WCNT_W-1:0]   cnt_ff, cnt_in;
   logic [wwcm_pkg::MOD_W-1:0]    mod_ff, mod_in;
   logic [wwcm_pkg::PER_W-1:0]    offset_ff, offset_in;
   logic [wwcm_pkg::CH_W-1:0]     first_ff, first_in;

   // Derived configuration values.
   logic [wwcm_pkg::CC_W-1:0]     cry_eff;
   logic [wwcm_pkg::MPC_W-1:0]    nmod_eff;
   logic [wwcm_pkg::MODCAP_W-1:0] cap_mods;
   logic [wwcm_pkg::AU2_W-1:0]    au2;
   logic [wwcm_pkg::UV2_W-1:0]    uv2;
   logic [wwcm_pkg::PER_W-1:0]    per;

   // Wire-to-channel lookup values.
   logic [wwcm_pkg::WIRE_W-1:0]   w2c_a;
   logic [wwcm_pkg::AU2_W-1:0]    w2c_ncha;
   logic [wwcm_pkg::PER_W-1:0]    w2c_off;
   logic [wwcm_pkg::WNUM_W-1:0]   w2c_pos;
   logic [wwcm_pkg::MOD_W-1:0]    w2c_mod;
   logic                          w2c_bad;

   // Handshake and unit connections.
   logic                          accept;
   logic                          push;
   wwcm_pkg::rsp_type             push_data;
   logic                          slot_free;
   logic [wwcm_pkg::WNUM_W-1:0]   next_wnum;
   logic                          emit_last;
   logic                          wire_ok;
   logic                          in_range;
   wwcm_pkg::div_req_type         div_req;
   wwcm_pkg::div_rsp_type         div_rsp;

   assign accept = req_valid && !req_stall;

   // Configuration register writes.
   always_comb begin
      cc_in  = cc_ff;
      mpc_in = mpc_ff;
      wu_in  = wu_ff;
      wv_in  = wv_ff;
      wz_in  = wz_ff;
      au_in  = au_ff;
      av_in  = av_ff;
      if (csr_we) begin
         unique case (csr_index)
            wwcm_pkg::REG_CRYOSTAT_COUNT:       cc_in  = csr_wdata[wwcm_pkg::CC_W-1:0];
            wwcm_pkg::REG_MODULES_PER_CRYOSTAT: mpc_in = csr_wdata[wwcm_pkg::MPC_W-1:0];
            wwcm_pkg::REG_WIRES_U:              wu_in  = csr_wdata;
            wwcm_pkg::REG_WIRES_V:              wv_in  = csr_wdata;
            wwcm_pkg::REG_WIRES_Z:              wz_in  = csr_wdata;
            wwcm_pkg::REG_ANCHORED_U:           au_in  = csr_wdata;
            wwcm_pkg::REG_ANCHORED_V:           av_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= wwcm_pkg::CC_W'(1);
         mpc_ff <= wwcm_pkg::MPC_W'(1);
         wu_ff  <= wwcm_pkg::WIRE_W'(1);
         wv_ff  <= wwcm_pkg::WIRE_W'(1);
         wz_ff  <= wwcm_pkg::WIRE_W'(1);
         au_ff  <= wwcm_pkg::WIRE_W'(1);
         av_ff  <= wwcm_pkg::WIRE_W'(1);
      end else begin
         cc_ff  <= cc_in;
         mpc_ff <= mpc_in;
         wu_ff  <= wu_in;
         wv_ff  <= wv_in;
         wz_ff  <= wz_in;
         au_ff  <= au_in;
         av_ff  <= av_in;
      end
   end

   // Effective counts and readout group boundaries within a module.
   always_comb begin
      cry_eff  = (cc_ff > wwcm_pkg::CC_W'(wwcm_pkg::MAX_CRYOSTATS)) ?
                 wwcm_pkg::CC_W'(wwcm_pkg::MAX_CRYOSTATS) : cc_ff;
      nmod_eff = (mpc_ff > wwcm_pkg::MPC_W'(wwcm_pkg::MAX_MODULES)) ?
                 wwcm_pkg::MPC_W'(wwcm_pkg::MAX_MODULES) : mpc_ff;
      cap_mods = wwcm_pkg::MODCAP_W'(cry_eff) * wwcm_pkg::MODCAP_W'(nmod_eff);
      au2      = {au_ff, 1'b0};
      uv2      = wwcm_pkg::UV2_W'(au2) + wwcm_pkg::UV2_W'({av_ff, 1'b0});
      per      = wwcm_pkg::PER_W'(uv2) + wwcm_pkg::PER_W'({wz_ff, 1'b0});
   end

   // Wire-to-channel: group period, channel count and group start in the module.
   always_comb begin
      unique case (pla_ff)
         wwcm_pkg::PLANE_U: begin
            w2c_a    = au_ff;
            w2c_ncha = au2;
            w2c_off  = '0;
         end
         wwcm_pkg::PLANE_V: begin
            w2c_a    = av_ff;
            w2c_ncha = {av_ff, 1'b0};
            w2c_off  = wwcm_pkg::PER_W'(au2);
         end
         wwcm_pkg::PLANE_Z: begin
            w2c_a    = '0;
            w2c_ncha = wwcm_pkg::AU2_W'(wz_ff);
            w2c_off  = wwcm_pkg::PER_W'(uv2) +
                       (vol_ff[0] ? wwcm_pkg::PER_W'(wz_ff) : '0);
         end
         default: begin
            w2c_a    = '0;
            w2c_ncha = '0;
            w2c_off  = '0;
         end
      endcase
      w2c_pos = wnum_ff + (vol_ff[0] ? wwcm_pkg::WNUM_W'(w2c_a) : '0);
      w2c_mod = wwcm_pkg::MOD_W'(cry_ff) * wwcm_pkg::MOD_W'(nmod_eff) +
                wwcm_pkg::MOD_W'(vol_ff[wwcm_pkg::VOL_W-1:1]);
      w2c_bad = ({1'b0, cry_ff} >= cry_eff) ||
                ({1'b0, vol_ff} >= {nmod_eff, 1'b0}) ||
                (pla_ff == wwcm_pkg::PLANE_NONE) ||
                (w2c_ncha == '0);
   end

   // Wire emission: current wire in the plane and whether it is the final one.
   always_comb begin
      wire_ok   = (wnum_ff < wwcm_pkg::WNUM_W'(nw_ff));
      next_wnum = wnum_ff + wwcm_pkg::WNUM_W'(a_ff);
      emit_last = (next_wnum >= wwcm_pkg::WNUM_W'(nw_ff)) ||
                  (cnt_ff == wwcm_pkg::WCNT_W'(wwcm_pkg::MAX_WIRES - 1));
      in_range  = (div_rsp.quot < wwcm_pkg::CH_W'(cap_mods));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wwcm_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.action == wwcm_pkg::ACTION_W2C) begin
                  state_in = wwcm_pkg::S_W2C_CHECK;
               end else if ((per == '0) || (nmod_eff == '0)) begin
                  state_in = wwcm_pkg::S_INVALID;
               end else begin
                  state_in = wwcm_pkg::S_DIV_CH;
               end
            end
         end
         wwcm_pkg::S_DIV_CH: begin
            if (div_rsp.done) begin
               state_in = wwcm_pkg::S_RANGE;
            end
         end
         wwcm_pkg::S_RANGE: begin
            state_in = in_range ? wwcm_pkg::S_DIV_MOD : wwcm_pkg::S_INVALID;
         end
         wwcm_pkg::S_DIV_MOD: begin
            if (div_rsp.done) begin
               state_in = wwcm_pkg::S_CLASSIFY;
            end
         end
         wwcm_pkg::S_CLASSIFY: state_in = wwcm_pkg::S_SETUP;
         wwcm_pkg::S_SETUP:    state_in = wwcm_pkg::S_EMIT;
         wwcm_pkg::S_EMIT: begin
            if (!wire_ok) begin
               state_in = wwcm_pkg::S_INVALID;
            end else if (slot_free && emit_last) begin
               state_in = wwcm_pkg::S_IDLE;
            end
         end
         wwcm_pkg::S_INVALID: begin
            if (slot_free) begin
               state_in = wwcm_pkg::S_IDLE;
            end
         end
         wwcm_pkg::S_W2C_CHECK: begin
            state_in = w2c_bad ? wwcm_pkg::S_INVALID : wwcm_pkg::S_W2C_DIV;
         end
         wwcm_pkg::S_W2C_DIV: begin
            if (div_rsp.done) begin
               state_in = wwcm_pkg::S_W2C_OUT;
            end
         end
         wwcm_pkg::S_W2C_OUT: begin
            if (slot_free) begin
               state_in = wwcm_pkg::S_IDLE;
            end
         end
         default: state_in = wwcm_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: request stall, divider commands and result pushes.
   always_comb begin
      req_stall        = 1'b1;
      div_req.start    = 1'b0;
      div_req.dividend = req_data.channel_in;
      div_req.divisor  = per;
      push             = 1'b0;
      push_data        = '0;
      push_data.last   = 1'b1;
      unique case (state_ff)
         wwcm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (accept && (req_data.action == wwcm_pkg::ACTION_C2W) &&
                (per != '0) && (nmod_eff != '0)) begin
               div_req.start = 1'b1;
            end
         end
         wwcm_pkg::S_RANGE: begin
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = wwcm_pkg::PER_W'(nmod_eff);
            div_req.start    = in_range;
         end
         wwcm_pkg::S_EMIT: begin
            push                   = wire_ok && slot_free;
            push_data.valid_res    = 1'b1;
            push_data.last         = emit_last;
            push_data.cryostat_out = cry_ff;
            push_data.volume_out   = {vol_ff[wwcm_pkg::VOL_W-1:1], odd_ff};
            push_data.plane_out    = pla_ff;
            push_data.wire_out     = wnum_ff[wwcm_pkg::WIRE_W-1:0];
            push_data.channel_out  = ch_ff;
         end
         wwcm_pkg::S_INVALID: begin
            push = slot_free;
         end
         wwcm_pkg::S_W2C_CHECK: begin
            div_req.dividend = wwcm_pkg::CH_W'(w2c_pos);
            div_req.divisor  = wwcm_pkg::PER_W'(w2c_ncha);
            div_req.start    = !w2c_bad;
         end
         wwcm_pkg::S_W2C_OUT: begin
            push                   = slot_free;
            push_data.valid_res    = 1'b1;
            push_data.cryostat_out = cry_ff;
            push_data.volume_out   = vol_ff;
            push_data.plane_out    = pla_ff;
            push_data.wire_out     = wnum_ff[wwcm_pkg::WIRE_W-1:0];
            push_data.channel_out  = first_ff + wwcm_pkg::CH_W'(offset_ff) +
                                     wwcm_pkg::CH_W'(div_rsp.rem);
         end
         default: begin
         end
      endcase
   end

   // Per-transaction datapath registers.
   always_comb begin
      ch_in     = ch_ff;
      cry_in    = cry_ff;
      vol_in    = vol_ff;
      pla_in    = pla_ff;
      wnum_in   = wnum_ff;
      odd_in    = odd_ff;
      rr_in     = rr_ff;
      a_in      = a_ff;
      nw_in     = nw_ff;
      cnt_in    = cnt_ff;
      mod_in    = mod_ff;
      offset_in = offset_ff;
      first_in  = first_ff;
      unique case (state_ff)
         wwcm_pkg::S_IDLE: begin
            if (accept) begin
               ch_in   = req_data.channel_in;
               cry_in  = req_data.cryostat_in;
               vol_in  = req_data.volume_in;
               pla_in  = req_data.plane_in;
               wnum_in = wwcm_pkg::WNUM_W'(req_data.wire_in);
            end
         end
         wwcm_pkg::S_DIV_CH: begin
            // Remainder is the position of the channel within its module.
            if (div_rsp.done) begin
               rr_in = div_rsp.rem;
            end
         end
         wwcm_pkg::S_DIV_MOD: begin
            // Quotient is the cryostat, remainder the module within it.
            if (div_rsp.done) begin
               cry_in = div_rsp.quot[wwcm_pkg::CRY_W-1:0];
               vol_in = {div_rsp.rem[wwcm_pkg::VOL_W-2:0], 1'b0};
            end
         end
         wwcm_pkg::S_CLASSIFY: begin
            // Pick the readout group and the position inside it.
            if (rr_ff < wwcm_pkg::PER_W'(au2)) begin
               pla_in = wwcm_pkg::PLANE_U;
               a_in   = au_ff;
               nw_in  = wu_ff;
            end else if (rr_ff < wwcm_pkg::PER_W'(uv2)) begin
               pla_in = wwcm_pkg::PLANE_V;
               rr_in  = rr_ff - wwcm_pkg::PER_W'(au2);
               a_in   = av_ff;
               nw_in  = wv_ff;
            end else begin
               pla_in = wwcm_pkg::PLANE_Z;
               rr_in  = rr_ff - wwcm_pkg::PER_W'(uv2);
               a_in   = wz_ff;
               nw_in  = wz_ff;
            end
         end
         wwcm_pkg::S_SETUP: begin
            // Positions at or past one period start in the odd volume.
            cnt_in = '0;
            if (rr_ff >= wwcm_pkg::PER_W'(a_ff)) begin
               wnum_in = wwcm_pkg::WNUM_W'(rr_ff - wwcm_pkg::PER_W'(a_ff));
               odd_in  = 1'b1;
            end else begin
               wnum_in = wwcm_pkg::WNUM_W'(rr_ff);
               odd_in  = 1'b0;
            end
         end
         wwcm_pkg::S_EMIT: begin
            // Each further wire lies one period on, in the other volume.
            if (push) begin
               wnum_in = next_wnum;
               odd_in  = !odd_ff;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         wwcm_pkg::S_W2C_CHECK: begin
            mod_in    = w2c_mod;
            offset_in = w2c_off;
         end
         wwcm_pkg::S_W2C_DIV: begin
            first_in = wwcm_pkg::CH_W'(mod_ff) * wwcm_pkg::CH_W'(per);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wwcm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ch_ff     <= ch_in;
      cry_ff    <= cry_in;
      vol_ff    <= vol_in;
      pla_ff    <= pla_in;
      wnum_ff   <= wnum_in;
      odd_ff    <= odd_in;
      rr_ff     <= rr_in;
      a_ff      <= a_in;
      nw_ff     <= nw_in;
      cnt_ff    <= cnt_in;
      mod_ff    <= mod_in;
      offset_ff <= offset_in;
      first_ff  <= first_in;
   end

   // Shared divider.
   wwcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output register.
   wwcm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A result is only written into a free output slot.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("result pushed into an occupied output register");

   // The final result of a transaction returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.last) |=> (state_ff == wwcm_pkg::S_IDLE))
      else $error("sequencer not idle after final result");

   // While waiting on a division the divider is working or has just finished.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wwcm_pkg::S_DIV_CH) || (state_ff == wwcm_pkg::S_DIV_MOD) ||
       (state_ff == wwcm_pkg::S_W2C_DIV)) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on an idle divider");

endmodule

// ===== tb/wrapped_wire_channel_map_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Wrapped wire channel map core testbench
// Drives channel and wire lookups through the request channel under random
// gaps and stalls, across several register settings from minimum to maximum,
// including settings that wrap register values and empty readout groups.
// Every accepted request is predicted in the bench, and each response is
// compared field by field with the oldest pending prediction.
// ---------------------------------------------------------------------------
module wrapped_wire_channel_map_core_test;

   // Clock, reset and block ports; all inputs start at known values.
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   wwcm_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   wwcm_pkg::rsp_type               rsp_data;
   logic                            csr_we = 1'b0;
   logic [wwcm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [wwcm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Bench copy of the configuration registers.
   logic [wwcm_pkg::CC_W-1:0]   cfg_cryostats;
   logic [wwcm_pkg::MPC_W-1:0]  cfg_modules;
   logic [wwcm_pkg::WIRE_W-1:0] cfg_wires_u;
   logic [wwcm_pkg::WIRE_W-1:0] cfg_wires_v;
   logic [wwcm_pkg::WIRE_W-1:0] cfg_wires_z;
   logic [wwcm_pkg::WIRE_W-1:0] cfg_anch_u;
   logic [wwcm_pkg::WIRE_W-1:0] cfg_anch_v;

   // Lookups waiting to be sent and responses waiting to arrive.
   wwcm_pkg::req_type pending_lookups[$];
   wwcm_pkg::rsp_type expected_rsps[$];
   int                lookups_queued = 0;
   int                lookups_taken = 0;
   int                error_count = 0;

   // Sender and receiver pacing.
   int                send_gap = 0;
   bit                calm_send = 1'b0;
   int                recv_wait = 0;
   int                recv_hold = 0;
   bit                calm_recv = 1'b0;
   int                rsps_seen = 0;
   wwcm_pkg::rsp_type got_rsp;

   wrapped_wire_channel_map_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 12 ns period.
   initial begin
      forever #6 clock = ~clock;
   end

   // Reset is held at the start of the run only, then released.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Give up well past the slowest correct run.
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Effective counts after the clamps on oversized register values.
   function automatic int unsigned eff_cryostats();
      int unsigned n;
      n = 32'(cfg_cryostats);
      return (n > wwcm_pkg::MAX_CRYOSTATS) ? wwcm_pkg::MAX_CRYOSTATS : n;
   endfunction

   function automatic int unsigned eff_modules();
      int unsigned n;
      n = 32'(cfg_modules);
      return (n > wwcm_pkg::MAX_MODULES) ? wwcm_pkg::MAX_MODULES : n;
   endfunction

   function automatic int unsigned module_channels();
      int unsigned au, av, wz;
      au = 32'(cfg_anch_u);
      av = 32'(cfg_anch_v);
      wz = 32'(cfg_wires_z);
      return 2 * (au + av + wz);
   endfunction

   function automatic int unsigned channel_total();
      return eff_cryostats() * eff_modules() * module_channels();
   endfunction

   function automatic wwcm_pkg::rsp_type make_rsp(logic ok, logic fin, int unsigned cry,
                                                  int unsigned vol,
                                                  logic [wwcm_pkg::PLANE_W-1:0] pl,
                                                  int unsigned wire_idx, int unsigned ch);
      wwcm_pkg::rsp_type t;
      t.valid_res    = ok;
      t.last         = fin;
      t.cryostat_out = cry[wwcm_pkg::CRY_W-1:0];
      t.volume_out   = vol[wwcm_pkg::VOL_W-1:0];
      t.plane_out    = pl;
      t.wire_out     = wire_idx[wwcm_pkg::WIRE_W-1:0];
      t.channel_out  = ch[wwcm_pkg::CH_W-1:0];
      return t;
   endfunction

   // Append one predicted response transaction.
   function automatic void queue_expected(wwcm_pkg::rsp_type t);
      expected_rsps.insert(expected_rsps.size(), t);
   endfunction

   // Work out every response that one lookup causes and queue it.
   function automatic void predict_lookup(wwcm_pkg::req_type r);
      int unsigned n_cry, n_mod, per, ch, m, pos, cry, v1, v2, vol, w, span, lim;
      int unsigned au, av, wu, wv, wz, first, ncha;
      logic [wwcm_pkg::PLANE_W-1:0] pl;
      int      cnt;
      wwcm_pkg::rsp_type held;
      n_cry = eff_cryostats();
      n_mod = eff_modules();
      per   = module_channels();
      au = 32'(cfg_anch_u);
      av = 32'(cfg_anch_v);
      wu = 32'(cfg_wires_u);
      wv = 32'(cfg_wires_v);
      wz = 32'(cfg_wires_z);
      if (r.action == wwcm_pkg::ACTION_C2W) begin
         ch = 32'(r.channel_in);
         // An empty map has a total of zero, so every channel is out of range.
         if (ch >= channel_total()) begin
            queue_expected(make_rsp(1'b0, 1'b1, 0, 0, wwcm_pkg::PLANE_U, 0, 0));
            return;
         end
         m   = ch / per;
         pos = ch % per;
         cry = m / n_mod;
         v1  = 2 * (m % n_mod);
         v2  = v1 + 1;
         if (pos < 2 * au) begin
            pl = wwcm_pkg::PLANE_U;
            span = au;
            lim = wu;
         end else if (pos < 2 * au + 2 * av) begin
            pos -= 2 * au;
            pl = wwcm_pkg::PLANE_V;
            span = av;
            lim = wv;
         end else begin
            pos -= 2 * au + 2 * av;
            pl = wwcm_pkg::PLANE_Z;
            span = wz;
            lim = wz;
            if (pos >= wz) begin
               pos -= wz;
               v1 = v2;
            end
         end
         // Wrapped planes start on the odd volume past one period.
         vol = v1;
         w = pos;
         if (pl != wwcm_pkg::PLANE_Z && w >= span) begin
            vol = v2;
            w -= span;
         end
         // Walk the wrap, switching volume on each step, up to the wire cap.
         cnt = 0;
         while (w < lim && cnt < wwcm_pkg::MAX_WIRES) begin
            if (cnt != 0) queue_expected(held);
            held = make_rsp(1'b1, 1'b0, cry, vol, pl, w, ch);
            cnt++;
            w += span;
            vol = (vol == v1) ? v2 : v1;
         end
         if (cnt == 0) begin
            held = make_rsp(1'b0, 1'b1, 0, 0, wwcm_pkg::PLANE_U, 0, 0);
         end
         held.last = 1'b1;
         queue_expected(held);
      end else begin
         if (32'(r.cryostat_in) >= n_cry || 32'(r.volume_in) >= 2 * n_mod ||
             r.plane_in == wwcm_pkg::PLANE_NONE) begin
            queue_expected(make_rsp(1'b0, 1'b1, 0, 0, wwcm_pkg::PLANE_U, 0, 0));
            return;
         end
         m     = 32'(r.cryostat_in) * n_mod + 32'(r.volume_in) / 2;
         first = m * per;
         pos   = 32'(r.wire_in);
         if (r.plane_in == wwcm_pkg::PLANE_U) begin
            ncha = 2 * au;
            if (r.volume_in[0]) pos += au;
         end else if (r.plane_in == wwcm_pkg::PLANE_V) begin
            first += 2 * au;
            ncha = 2 * av;
            if (r.volume_in[0]) pos += av;
         end else begin
            first += 2 * au + 2 * av + (r.volume_in[0] ? wz : 0);
            ncha = wz;
         end
         // A readout group with no channels cannot hold the wire.
         if (ncha == 0) begin
            queue_expected(make_rsp(1'b0, 1'b1, 0, 0, wwcm_pkg::PLANE_U, 0, 0));
            return;
         end
         queue_expected(make_rsp(1'b1, 1'b1, 32'(r.cryostat_in), 32'(r.volume_in),
                                 r.plane_in, 32'(r.wire_in), first + pos % ncha));
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v,
                                       logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   // Register writes update the bench copy on the same edge as the block.
   always @(posedge clock) begin
      if (reset) begin
         cfg_cryostats <= wwcm_pkg::CC_W'(1);
         cfg_modules   <= wwcm_pkg::MPC_W'(1);
         cfg_wires_u   <= wwcm_pkg::WIRE_W'(1);
         cfg_wires_v   <= wwcm_pkg::WIRE_W'(1);
         cfg_wires_z   <= wwcm_pkg::WIRE_W'(1);
         cfg_anch_u    <= wwcm_pkg::WIRE_W'(1);
         cfg_anch_v    <= wwcm_pkg::WIRE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            wwcm_pkg::REG_CRYOSTAT_COUNT:
               cfg_cryostats <= csr_wdata[wwcm_pkg::CC_W-1:0];
            wwcm_pkg::REG_MODULES_PER_CRYOSTAT:
               cfg_modules <= csr_wdata[wwcm_pkg::MPC_W-1:0];
            wwcm_pkg::REG_WIRES_U:    cfg_wires_u <= csr_wdata;
            wwcm_pkg::REG_WIRES_V:    cfg_wires_v <= csr_wdata;
            wwcm_pkg::REG_WIRES_Z:    cfg_wires_z <= csr_wdata;
            wwcm_pkg::REG_ANCHORED_U: cfg_anch_u <= csr_wdata;
            wwcm_pkg::REG_ANCHORED_V: cfg_anch_v <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request driver: predicts each accepted transaction, then offers the
   // next one after a random gap, holding the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_lookup(req_data);
            lookups_taken++;
         end
         if (req_valid && req_stall) begin
            // Stalled: keep the transaction on the port.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_lookups.size() != 0) begin
            req_data  <= pending_lookups.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 24) == 0) calm_send = !calm_send;
            send_gap = calm_send ? 0 : int'($urandom_range(0, 11));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each accepted transaction and paces the stall,
   // with two long hold-offs that back the block up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with no lookup pending");
               error_count++;
            end else begin
               got_rsp = expected_rsps.pop_front();
               check_field("valid_res", 32'(got_rsp.valid_res), 32'(rsp_data.valid_res));
               check_field("last", 32'(got_rsp.last), 32'(rsp_data.last));
               check_field("cryostat_out", 32'(got_rsp.cryostat_out),
                           32'(rsp_data.cryostat_out));
               check_field("volume_out", 32'(got_rsp.volume_out),
                           32'(rsp_data.volume_out));
               check_field("plane_out", 32'(got_rsp.plane_out), 32'(rsp_data.plane_out));
               check_field("wire_out", 32'(got_rsp.wire_out), 32'(rsp_data.wire_out));
               check_field("channel_out", 32'(got_rsp.channel_out),
                           32'(rsp_data.channel_out));
            end
            if ($urandom_range(0, 24) == 0) calm_recv = !calm_recv;
            recv_wait = calm_recv ? 0 : int'($urandom_range(0, 11));
            if (rsps_seen == 60 || rsps_seen == 400) recv_hold = 400;
         end else begin
            if (recv_wait > 0) recv_wait--;
            if (recv_hold > 0) recv_hold--;
         end
         rsp_stall <= (recv_wait > 0) || (recv_hold > 0);
      end
   end

   task automatic queue_lookup(wwcm_pkg::req_type r);
      pending_lookups.insert(pending_lookups.size(), r);
      lookups_queued++;
   endtask

   // Request with every field random.
   function automatic wwcm_pkg::req_type noise_req();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(wwcm_pkg::req_type)-1:0];
   endfunction

   // Channel lookup with the unused fields left random.
   function automatic wwcm_pkg::req_type chan_lookup(int unsigned ch);
      wwcm_pkg::req_type r;
      r = noise_req();
      r.action = wwcm_pkg::ACTION_C2W;
      r.channel_in = ch[wwcm_pkg::CH_W-1:0];
      return r;
   endfunction

   function automatic wwcm_pkg::req_type wire_lookup(int unsigned cry, int unsigned vol,
                                                     logic [wwcm_pkg::PLANE_W-1:0] pl,
                                                     int unsigned wire_idx);
      wwcm_pkg::req_type r;
      r = noise_req();
      r.action = wwcm_pkg::ACTION_W2C;
      r.cryostat_in = cry[wwcm_pkg::CRY_W-1:0];
      r.volume_in = vol[wwcm_pkg::VOL_W-1:0];
      r.plane_in = pl;
      r.wire_in = wire_idx[wwcm_pkg::WIRE_W-1:0];
      return r;
   endfunction

   // Mostly in-range lookups, some near the channel limit, some raw noise.
   function automatic wwcm_pkg::req_type random_lookup();
      wwcm_pkg::req_type r;
      int unsigned total, n_cry, n_mod, sel, near;
      r = noise_req();
      total = channel_total();
      n_cry = eff_cryostats();
      n_mod = eff_modules();
      sel = $urandom_range(0, 99);
      if (r.action == wwcm_pkg::ACTION_C2W) begin
         if (sel < 75 && total != 0) begin
            r.channel_in = wwcm_pkg::CH_W'($urandom_range(0, total - 1));
         end else if (sel < 88) begin
            near = (total < 2) ? $urandom_range(0, 3) : total - 2 + $urandom_range(0, 3);
            r.channel_in = wwcm_pkg::CH_W'(near);
         end
      end else if (sel < 85 && n_cry != 0 && n_mod != 0) begin
         r.cryostat_in = wwcm_pkg::CRY_W'($urandom_range(0, n_cry - 1));
         r.volume_in = wwcm_pkg::VOL_W'($urandom_range(0, 2 * n_mod - 1));
         r.plane_in = wwcm_pkg::PLANE_W'($urandom_range(0, 2));
         if (sel < 45) r.wire_in = wwcm_pkg::WIRE_W'($urandom_range(0, 63));
      end
      return r;
   endfunction

   task automatic queue_random(int count);
      repeat (count) queue_lookup(random_lookup());
   endtask

   // Wait until every lookup has been sent and answered, then let it settle.
   task automatic wait_drained();
      while (lookups_taken != lookups_queued || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all seven registers on consecutive cycles while the block is idle.
   task automatic load_setting(int unsigned cc, int unsigned mpc, int unsigned wu,
                               int unsigned wv, int unsigned wz, int unsigned au,
                               int unsigned av);
      logic [wwcm_pkg::CSR_IDX_W-1:0]  order[7];
      logic [wwcm_pkg::CSR_DATA_W-1:0] vals[7];
      order = '{wwcm_pkg::REG_CRYOSTAT_COUNT, wwcm_pkg::REG_MODULES_PER_CRYOSTAT,
                wwcm_pkg::REG_WIRES_U, wwcm_pkg::REG_WIRES_V, wwcm_pkg::REG_WIRES_Z,
                wwcm_pkg::REG_ANCHORED_U, wwcm_pkg::REG_ANCHORED_V};
      vals = '{wwcm_pkg::CSR_DATA_W'(cc), wwcm_pkg::CSR_DATA_W'(mpc),
               wwcm_pkg::CSR_DATA_W'(wu), wwcm_pkg::CSR_DATA_W'(wv),
               wwcm_pkg::CSR_DATA_W'(wz), wwcm_pkg::CSR_DATA_W'(au),
               wwcm_pkg::CSR_DATA_W'(av)};
      wait_drained();
      csr_we <= 1'b1;
      for (int i = 0; i < 7; i++) begin
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stimulus: reset values first, then directed and random phases.
   initial begin
      int unsigned wu, wv;
      @(negedge reset);
      @(posedge clock);
      queue_random(10);

      // Two cryostats of three modules with short wrapped planes.
      load_setting(2, 3, 10, 9, 6, 3, 4);
      queue_lookup(chan_lookup(0));
      queue_lookup(chan_lookup(3));
      queue_lookup(chan_lookup(6));
      queue_lookup(chan_lookup(14));
      queue_lookup(chan_lookup(20));
      queue_lookup(chan_lookup(25));
      queue_lookup(chan_lookup(155));
      queue_lookup(chan_lookup(156));
      queue_lookup(chan_lookup(4194303));
      queue_lookup(wire_lookup(0, 0, wwcm_pkg::PLANE_U, 0));
      queue_lookup(wire_lookup(1, 5, wwcm_pkg::PLANE_U, 2047));
      queue_lookup(wire_lookup(1, 5, wwcm_pkg::PLANE_V, 7));
      queue_lookup(wire_lookup(0, 0, wwcm_pkg::PLANE_NONE, 1));
      queue_lookup(wire_lookup(2, 0, wwcm_pkg::PLANE_U, 0));
      queue_lookup(wire_lookup(0, 6, wwcm_pkg::PLANE_V, 0));
      queue_random(60);

      // Long U planes that overflow the wire cap, V period above its plane.
      load_setting(1, 1, 2047, 3, 1, 1, 5);
      queue_lookup(chan_lookup(0));
      queue_lookup(chan_lookup(1));
      queue_lookup(chan_lookup(6));
      queue_lookup(chan_lookup(13));
      queue_lookup(wire_lookup(0, 1, wwcm_pkg::PLANE_U, 2047));
      queue_random(40);

      // Largest map.
      load_setting(4, 64, 2047, 2047, 2047, 2047, 2047);
      queue_lookup(chan_lookup(3144191));
      queue_lookup(chan_lookup(3144192));
      queue_lookup(wire_lookup(3, 127, wwcm_pkg::PLANE_Z, 2047));
      queue_lookup(wire_lookup(3, 127, wwcm_pkg::PLANE_U, 2047));
      queue_random(60);

      // Oversized counts fold into the clamps.
      load_setting(2047, 2047, 2047, 100, 30, 600, 7);
      queue_random(50);

      // Empty U group and V plane without wires.
      load_setting(3, 5, 40, 0, 17, 0, 2);
      queue_lookup(chan_lookup(0));
      queue_lookup(wire_lookup(0, 0, wwcm_pkg::PLANE_U, 5));
      queue_random(50);

      // No cryostats and no modules: every lookup is invalid.
      load_setting(0, 0, 5, 5, 5, 2, 2);
      queue_random(20);

      // Small random maps with deep wraps.
      repeat (4) begin
         wu = $urandom_range(1, 40);
         wv = $urandom_range(1, 40);
         load_setting($urandom_range(1, 4), $urandom_range(1, 8), wu, wv,
                      $urandom_range(1, 20), $urandom_range(1, wu + 3),
                      $urandom_range(1, wv + 3));
         queue_random(30);
      end

      // Smallest map.
      load_setting(1, 1, 1, 1, 1, 1, 1);
      queue_random(30);

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wwcm_pkg.sv
rtl/wwcm_div.sv
rtl/wwcm_rsp_reg.sv
rtl/wrapped_wire_channel_map_core.sv
tb/wrapped_wire_channel_map_core_test.sv
